>>> design/udff_pkg.sv
`timescale 1ns / 1ps

package udff_pkg;

  // default field limit, width and precision saturate here
  localparam int MAX_FIELD_DEF = 64;

  // decimal digits needed for a 64-bit operand
  localparam int NDIG = 20;

  localparam int VAL_W  = 64;
  localparam int CNT_W  = 7;
  localparam int CHAR_W = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRECISION    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_JUSTIFY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PAD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPERAND_SIZE = 3'd4;

  // operand size codes
  localparam logic [1:0] OPSZ_32 = 2'd0;
  localparam logic [1:0] OPSZ_16 = 2'd1;
  localparam logic [1:0] OPSZ_8  = 2'd2;
  localparam logic [1:0] OPSZ_64 = 2'd3;

  typedef struct packed {
    logic [6:0] field_width;
    logic [7:0] precision;
    logic       left_justify;
    logic       zero_pad;
    logic [1:0] operand_size;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic size;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_last;
    logic total_zero;
    logic last;
  } dp_sts_t;

endpackage

>>> design/udff_ctrl.sv
`timescale 1ns / 1ps

module udff_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  udff_pkg::dp_sts_t sts,
  output udff_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import udff_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SIZE = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_last) begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = sts.total_zero ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  // checks
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("character strobe outside a transaction");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && sts.last) |=> !busy)
    else $error("still busy after the last character");

  a_emit_after_size: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_SIZE))
    else $error("emission started without sizing the field");

endmodule

>>> design/udff_dp.sv
`timescale 1ns / 1ps

module udff_dp #(
  parameter int MAX_FIELD = udff_pkg::MAX_FIELD_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  udff_pkg::cfg_t               cfg,
  input  logic [udff_pkg::VAL_W-1:0]   in_value,
  input  udff_pkg::dp_cmd_t            cmd,
  output udff_pkg::dp_sts_t            sts,
  output logic [udff_pkg::CHAR_W-1:0]  out_char_code,
  output logic                         out_is_last
);
  import udff_pkg::*;

  localparam int CW = $clog2(MAX_FIELD + 1);

  logic [VAL_W-1:0]        sh_r, sh_nxt;
  logic [NDIG-1:0][3:0]    bcd_r, bcd_nxt;
  logic [NDIG-1:0][3:0]    bcd_adj;
  logic [CNT_W-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic [CW-1:0]           ndig_r, ndig_nxt;
  logic [CW-1:0]           pad_r, pad_nxt;

  logic [4:0]    nd;
  logic          explicit_zero;
  logic [CW-1:0] prec_sat;
  logic [CW-1:0] width_sat;
  logic [CW-1:0] ndig_c;
  logic [CW-1:0] total_c;

  logic          in_pad;
  logic [CW-1:0] didx;
  logic [3:0]    dig;
  logic [CHAR_W-1:0] pad_char;

  // add-3 correction of every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end

  // significant digit count, none for explicit zero precision on zero
  always_comb begin
    nd = 5'd0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i] != 4'd0) begin
        nd = 5'(i + 1);
      end
    end
    explicit_zero = cfg.precision[7];
    if (nd == 5'd0 && !explicit_zero) begin
      nd = 5'd1;
    end
  end

  // field sizing from saturated width and precision
  always_comb begin
    if (explicit_zero) begin
      prec_sat = '0;
    end else if (32'(cfg.precision[6:0]) > MAX_FIELD) begin
      prec_sat = CW'(MAX_FIELD);
    end else begin
      prec_sat = CW'(cfg.precision[6:0]);
    end
    if (32'(cfg.field_width) > MAX_FIELD) begin
      width_sat = CW'(MAX_FIELD);
    end else begin
      width_sat = CW'(cfg.field_width);
    end
    ndig_c  = (CW'(nd) > prec_sat) ? CW'(nd) : prec_sat;
    total_c = (ndig_c > width_sat) ? ndig_c : width_sat;
  end

  // register next values
  always_comb begin
    sh_nxt      = sh_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    rem_nxt     = rem_r;
    ndig_nxt    = ndig_r;
    pad_nxt     = pad_r;
    if (cmd.load) begin
      bcd_nxt = '0;
      unique case (cfg.operand_size)
        OPSZ_32: begin
          sh_nxt      = {in_value[31:0], 32'd0};
          bit_cnt_nxt = 7'd32;
        end
        OPSZ_16: begin
          sh_nxt      = {in_value[15:0], 48'd0};
          bit_cnt_nxt = 7'd16;
        end
        OPSZ_8: begin
          sh_nxt      = {in_value[7:0], 56'd0};
          bit_cnt_nxt = 7'd8;
        end
        OPSZ_64: begin
          sh_nxt      = in_value;
          bit_cnt_nxt = 7'd64;
        end
        default: begin
          sh_nxt      = in_value;
          bit_cnt_nxt = 7'd64;
        end
      endcase
    end
    if (cmd.shift) begin
      bcd_nxt     = (NDIG*4)'({bcd_adj, sh_r[VAL_W-1]});
      sh_nxt      = {sh_r[VAL_W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r - 7'd1;
    end
    if (cmd.size) begin
      rem_nxt  = total_c;
      ndig_nxt = ndig_c;
      pad_nxt  = total_c - ndig_c;
    end
    if (cmd.emit) begin
      rem_nxt = rem_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      rem_r     <= '0;
    end else begin
      bit_cnt_r <= bit_cnt_nxt;
      rem_r     <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    bcd_r  <= bcd_nxt;
    ndig_r <= ndig_nxt;
    pad_r  <= pad_nxt;
  end

  // character at the current position, counted down from the end
  always_comb begin
    if (cfg.left_justify) begin
      in_pad = (rem_r <= pad_r);
      didx   = rem_r - CW'(1) - pad_r;
    end else begin
      in_pad = (rem_r > ndig_r);
      didx   = rem_r - CW'(1);
    end
    if (didx < CW'(NDIG)) begin
      dig = bcd_r[didx[4:0]];
    end else begin
      dig = 4'd0;
    end
    if (cfg.zero_pad && (cfg.precision == 8'd0) && !cfg.left_justify) begin
      pad_char = CH_ZERO;
    end else begin
      pad_char = CH_SPACE;
    end
    out_char_code = in_pad ? pad_char : (CH_ZERO + {2'b00, dig});
  end

  assign out_is_last = (rem_r == CW'(1));

  assign sts.conv_last  = (bit_cnt_r == 7'd1);
  assign sts.total_zero = (total_c == '0);
  assign sts.last       = (rem_r == CW'(1));

endmodule

>>> design/unsigned_decimal_field_formatter.sv
// sequence: load in S_IDLE, then one shift-add-3 step per operand bit (8/16/32/64 by operand size),
// sizing in S_SIZE, then one character per cycle on out_valid, the last flagged by out_is_last
// busy stays high until the last character, or until sizing if the field is empty; start is
// taken the cycle after, not while busy, so a new value waits until the last one is through
// the receiver cannot stall: each character is on the out_ ports for exactly one cycle
// reset: synchronous, active low; config registers clear to 0 and the controller goes idle
`timescale 1ns / 1ps

module unsigned_decimal_field_formatter #(
  parameter int MAX_FIELD = udff_pkg::MAX_FIELD_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [udff_pkg::VAL_W-1:0]        in_value,
  output logic                              out_valid,
  output logic [udff_pkg::CHAR_W-1:0]       out_char_code,
  output logic                              out_is_last,
  input  logic                              cfg_we,
  input  logic [udff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [udff_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import udff_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration register writes, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FIELD_WIDTH:  cfg_nxt.field_width  = cfg_data[6:0];
        REG_PRECISION:    cfg_nxt.precision    = cfg_data;
        REG_LEFT_JUSTIFY: cfg_nxt.left_justify = cfg_data[0];
        REG_ZERO_PAD:     cfg_nxt.zero_pad     = cfg_data[0];
        REG_OPERAND_SIZE: cfg_nxt.operand_size = cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  udff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  udff_dp #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

endmodule

>>> test/unsigned_decimal_field_formatter_tb.sv
`timescale 1ns / 1ps

module unsigned_decimal_field_formatter_tb;
  import udff_pkg::*;

  localparam int MAXF = MAX_FIELD_DEF;
  // cycles for one full 64-bit conversion plus a maximal field, with margin
  localparam int DRAIN_CYCLES = 140;
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [VAL_W-1:0]      in_value = '0;
  logic                  out_valid;
  logic [CHAR_W-1:0]     out_char_code;
  logic                  out_is_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_exp_t;

  // tracks field settings and the characters still owed by the block
  class field_text_checker;
    logic [6:0] width_reg;
    logic [7:0] prec_reg;
    logic       left_reg;
    logic       zpad_reg;
    logic [1:0] size_reg;
    char_exp_t  owed_chars[$];
    int         err_count;

    function new();
      width_reg = '0;
      prec_reg  = '0;
      left_reg  = 1'b0;
      zpad_reg  = 1'b0;
      size_reg  = OPSZ_32;
      err_count = 0;
    endfunction

    // builds the %u text of one accepted value and queues its characters
    function void note_value(logic [VAL_W-1:0] raw);
      logic [VAL_W-1:0]  v;
      logic [CHAR_W-1:0] digs[$];
      logic [CHAR_W-1:0] text[$];
      logic [CHAR_W-1:0] pad_char;
      int                wid, prec_min, ndig, total, pad;
      bit                expl_zero, prec_given;
      char_exp_t         e;
      case (size_reg)
        OPSZ_32: v = raw & 64'h0000_0000_FFFF_FFFF;
        OPSZ_16: v = raw & 64'h0000_0000_0000_FFFF;
        OPSZ_8:  v = raw & 64'h0000_0000_0000_00FF;
        default: v = raw;
      endcase
      wid = (int'(width_reg) > MAXF) ? MAXF : int'(width_reg);
      expl_zero = prec_reg[7];
      prec_given = (prec_reg != 8'd0);
      prec_min = 0;
      if (!expl_zero) prec_min = (int'(prec_reg) > MAXF) ? MAXF : int'(prec_reg);
      // digits, most significant first
      if (!(expl_zero && v == 0)) begin
        do begin
          digs.push_front(CH_ZERO + CHAR_W'(v % 64'd10));
          v = v / 64'd10;
        end while (v != 0);
      end
      ndig = (digs.size() > prec_min) ? digs.size() : prec_min;
      total = (ndig > wid) ? ndig : wid;
      pad = total - ndig;
      pad_char = (zpad_reg && !prec_given) ? CH_ZERO : CH_SPACE;
      if (!left_reg) repeat (pad) text.push_back(pad_char);
      repeat (ndig - digs.size()) text.push_back(CH_ZERO);
      foreach (digs[i]) text.push_back(digs[i]);
      if (left_reg) repeat (pad) text.push_back(CH_SPACE);
      foreach (text[i]) begin
        e.code = text[i];
        e.last = (i == text.size() - 1);
        owed_chars.push_back(e);
      end
    endfunction

    // compares one emitted character with the oldest owed one
    function void check_char(logic [CHAR_W-1:0] code, logic last);
      char_exp_t e;
      if (owed_chars.size() == 0) begin
        $error("unexpected character: char_code=%0d is_last=%0d", code, last);
        err_count++;
        return;
      end
      e = owed_chars.pop_front();
      if (code !== e.code) begin
        $error("char_code mismatch: expected %0d, actual %0d", e.code, code);
        err_count++;
      end
      if (last !== e.last) begin
        $error("is_last mismatch: expected %0d, actual %0d", e.last, last);
        err_count++;
      end
    endfunction
  endclass

  field_text_checker text_chk = new();
  int cycle_cnt = 0;

  unsigned_decimal_field_formatter uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) text_chk.check_char(out_char_code, out_is_last);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offers one value after a gap and returns at the edge that takes it
  task automatic send_value(input logic [VAL_W-1:0] v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    text_chk.note_value(v);
  endtask

  // drops start, waits out every owed character and any silent conversion
  task automatic settle();
    start <= 1'b0;
    while (text_chk.owed_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all five registers, then the unused indexes, which must not alias
  task automatic program_fields(input logic [7:0] width_raw, input logic [7:0] prec_raw,
                                input logic [7:0] left_raw, input logic [7:0] zpad_raw,
                                input logic [7:0] size_raw);
    logic [CFG_IDX_W-1:0] idx[$];
    logic [7:0]           dat[$];
    idx = '{REG_FIELD_WIDTH, REG_PRECISION, REG_LEFT_JUSTIFY, REG_ZERO_PAD,
            REG_OPERAND_SIZE, 3'd5, 3'd6, 3'd7};
    dat = '{width_raw, prec_raw, left_raw, zpad_raw, size_raw,
            8'($urandom), 8'($urandom), 8'($urandom)};
    foreach (idx[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= dat[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    text_chk.width_reg = width_raw[6:0];
    text_chk.prec_reg  = prec_raw;
    text_chk.left_reg  = left_raw[0];
    text_chk.zpad_reg  = zpad_raw[0];
    text_chk.size_reg  = size_raw[1:0];
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = VAL_W'($urandom_range(0, 20));
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  function automatic logic [7:0] rand_width();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'($urandom);
      default: return 8'($urandom_range(0, 24));
    endcase
  endfunction

  function automatic logic [7:0] rand_prec();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'hFF;
      2: return 8'($urandom_range(128, 255));
      3: return 8'($urandom);
      default: return 8'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin
    bit no_idle;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 32-bit operand, no width, no precision
    send_value(64'd0, $urandom_range(0, 14));
    send_value('1, $urandom_range(0, 14));
    send_value(64'd1, 0);
    send_value(64'd10, 0);
    settle();

    // full 64-bit operand, largest digit counts
    program_fields(8'd0, 8'd0, 8'd0, 8'd0, 8'(OPSZ_64));
    send_value('1, 0);
    send_value(64'd0, $urandom_range(0, 14));
    send_value(64'd10000000000000000000, 0);
    settle();

    // explicit zero precision, width 0: zero prints nothing
    program_fields(8'd0, 8'hFF, 8'd0, 8'd0, 8'(OPSZ_32));
    send_value(64'd0, 0);
    send_value(64'd5, 0);
    settle();

    // explicit zero precision with a width: only spaces, truncation to zero too
    program_fields(8'd5, 8'hFF, 8'd0, 8'd0, 8'(OPSZ_8));
    send_value(64'd0, 0);
    send_value(64'h100, 0);
    settle();

    // other negative precision, left justify overrides zero pad
    program_fields(8'd8, 8'h90, 8'd1, 8'd1, 8'(OPSZ_32));
    send_value(64'd0, 0);
    send_value(64'd123, 0);
    settle();

    // width above the limit saturates, zero padding active
    program_fields(8'hFF, 8'd0, 8'd0, 8'd1, 8'(OPSZ_16));
    send_value(64'd65535, 0);
    send_value(64'h12345, $urandom_range(0, 14));
    settle();

    // zero pad with a precision given pads with spaces
    program_fields(8'd10, 8'd3, 8'd0, 8'd1, 8'(OPSZ_8));
    send_value(64'd255, 0);
    send_value(64'd7, 0);
    send_value(64'h100, 0);
    settle();

    // precision above the limit saturates
    program_fields(8'd0, 8'd100, 8'd1, 8'd1, 8'(OPSZ_32));
    send_value(64'd42, 0);
    settle();

    // both at the limit
    program_fields(8'd64, 8'd64, 8'd0, 8'd0, 8'(OPSZ_64));
    send_value('1, 0);
    settle();

    // random settings and values
    repeat (10) begin
      program_fields(rand_width(), rand_prec(), 8'($urandom), 8'($urandom), 8'($urandom));
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (10) send_value(rand_value(), no_idle ? 0 : $urandom_range(0, 14));
      settle();
    end

    if (text_chk.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
